>>> rtl/odhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odhf_pkg
// Shared types and constants for the observation dedup hash filter.
// ----------------------------------------------------------------------------
package odhf_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0]  RSSI_THR_RESET = 8'd6;
    localparam logic [31:0] MOVE_THR_RESET = 32'd2700;

    localparam logic [1:0] CFG_RSSI_THR = 2'd0;
    localparam logic [1:0] CFG_MOVE_THR = 2'd1;

    localparam logic [1:0] OUT_DUP  = 2'd0;
    localparam logic [1:0] OUT_FWD  = 2'd1;
    localparam logic [1:0] OUT_FAIL = 2'd2;

    localparam logic [2:0] HASH_LAST = 3'd5;
    localparam logic [1:0] MOD_LAST  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [47:0] device_address;
        logic [7:0]  signal_level;
        logic [31:0] latitude_offset;
        logic [31:0] longitude_offset;
        logic        sink_accepts;
    } t_in_item;

    typedef struct packed {
        logic [1:0] outcome;
        logic       was_known;
        logic       table_full;
        logic [8:0] slot_index;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [47:0] address;
        logic [7:0]  signal;
        logic [31:0] latitude;
        logic [31:0] longitude;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_PINIT,
        S_READ,
        S_CHECK,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic hash;
        logic mod_step;
        logic pinit;
        logic rd;
        logic chk;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic mod_done;
        logic found;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/odhf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odhf_ctrl
// Sequencer: clear pass, hash, modulo, probe walk and commit.
// ----------------------------------------------------------------------------
module odhf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  odhf_pkg::t_sts i_sts,
    output odhf_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);

    odhf_pkg::t_state r_state;
    odhf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= odhf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            odhf_pkg::S_CLEAR:  if (i_sts.clr_done) n_state = odhf_pkg::S_IDLE;
            odhf_pkg::S_IDLE:   if (i_in_valid) n_state = odhf_pkg::S_HASH;
            odhf_pkg::S_HASH:   if (i_sts.hash_done) n_state = odhf_pkg::S_MOD;
            odhf_pkg::S_MOD:    if (i_sts.mod_done) n_state = odhf_pkg::S_PINIT;
            odhf_pkg::S_PINIT:  n_state = odhf_pkg::S_READ;
            odhf_pkg::S_READ:   n_state = odhf_pkg::S_CHECK;
            odhf_pkg::S_CHECK: begin
                if (i_sts.found || i_sts.last) n_state = odhf_pkg::S_DECIDE;
                else n_state = odhf_pkg::S_READ;
            end
            odhf_pkg::S_DECIDE: if (!i_sts.out_busy) n_state = odhf_pkg::S_IDLE;
            default:            n_state = odhf_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            odhf_pkg::S_CLEAR:  o_cmd.clr = 1'b1;
            odhf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            odhf_pkg::S_HASH:   o_cmd.hash = 1'b1;
            odhf_pkg::S_MOD:    o_cmd.mod_step = 1'b1;
            odhf_pkg::S_PINIT:  o_cmd.pinit = 1'b1;
            odhf_pkg::S_READ:   o_cmd.rd = 1'b1;
            odhf_pkg::S_CHECK:  o_cmd.chk = 1'b1;
            odhf_pkg::S_DECIDE: o_cmd.commit = !i_sts.out_busy;
            default:            o_cmd = '0;
        endcase
    end

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == odhf_pkg::S_CLEAR) |-> o_in_stall)
        else $error("input taken during clear pass");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.out_busy)
        else $error("commit into occupied output register");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == odhf_pkg::S_CHECK) |-> $past(r_state) == odhf_pkg::S_READ)
        else $error("slot check without read");

endmodule

>>> rtl/odhf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odhf_dp
// Datapath: FNV-1a hash, reciprocal modulo, probe walk, slot store, output.
// ----------------------------------------------------------------------------
module odhf_dp #(
    parameter int WIFI_SLOTS = 256,
    parameter int BLE_SLOTS  = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  odhf_pkg::t_cmd      i_cmd,
    output odhf_pkg::t_sts      o_sts,
    input  odhf_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output odhf_pkg::t_out_item o_out_data
);

    localparam int DEPTH    = WIFI_SLOTS + BLE_SLOTS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int MAX_SZ   = (WIFI_SLOTS > BLE_SLOTS) ? WIFI_SLOTS : BLE_SLOTS;
    localparam int SLOT_W   = $clog2(MAX_SZ);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [SLOT_W:0]   WIFI_SZ   = (SLOT_W + 1)'(WIFI_SLOTS);
    localparam logic [SLOT_W:0]   BLE_SZ    = (SLOT_W + 1)'(BLE_SLOTS);
    localparam logic [ADDR_W-1:0] BLE_BASE  = ADDR_W'(WIFI_SLOTS);
    localparam logic [31:0]       WIFI_RCP  = 32'((64'd1 << 32) / WIFI_SLOTS);
    localparam logic [31:0]       BLE_RCP   = 32'((64'd1 << 32) / BLE_SLOTS);

    odhf_pkg::t_entry r_mem [DEPTH];
    odhf_pkg::t_entry r_rdata;

    odhf_pkg::t_in_item  r_in;
    odhf_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [7:0]          r_rssi_thr;
    logic [31:0]         r_move_thr;
    logic [ADDR_W-1:0]   r_clr_idx;
    logic [31:0]         r_hash;
    logic [47:0]         r_hsh_addr;
    logic [2:0]          r_hash_cnt;
    logic [1:0]          r_mod_cnt;
    logic [31:0]         r_mq;
    logic [SLOT_W-1:0]   r_rem;
    logic [SLOT_W-1:0]   r_s;
    logic [SLOT_W:0]     r_cnt;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_known;
    logic                r_full;

    logic [SLOT_W:0]     size;
    logic [31:0]         size_w;
    logic [31:0]         rcp;
    logic [63:0]         rcp_prod;
    logic [ADDR_W-1:0]   base;
    logic [31:0]         hash_n;
    logic                slot_free;
    logic                slot_match;
    logic                last;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [9:0]          rssi_lim;
    logic [31:0]         dlat;
    logic [31:0]         dlon;
    logic                forward;
    logic [1:0]          outcome;

    assign size   = r_in.mode ? BLE_SZ : WIFI_SZ;
    assign size_w = 32'(size);
    assign rcp    = r_in.mode ? BLE_RCP : WIFI_RCP;
    assign base   = r_in.mode ? BLE_BASE : '0;

    assign hash_n = (r_hash ^ {24'd0, r_hsh_addr[47:40]}) * odhf_pkg::FNV_PRIME;

    // quotient estimate is exact or one short
    assign rcp_prod = {32'd0, r_hash} * {32'd0, rcp};

    assign slot_free  = !r_rdata.valid;
    assign slot_match = r_rdata.address == r_in.device_address;
    assign last       = r_cnt == (size - 1'b1);
    assign rd_addr    = base + ADDR_W'(r_s);
    assign wr_addr    = base + ADDR_W'(r_slot);

    assign rssi_lim = {2'b00, r_rdata.signal} + {2'b00, r_rssi_thr};
    assign dlat = (r_in.latitude_offset > r_rdata.latitude)
                ? (r_in.latitude_offset - r_rdata.latitude)
                : (r_rdata.latitude - r_in.latitude_offset);
    assign dlon = (r_in.longitude_offset > r_rdata.longitude)
                ? (r_in.longitude_offset - r_rdata.longitude)
                : (r_rdata.longitude - r_in.longitude_offset);

    always_comb begin
        forward = !r_known
               || ({2'b00, r_in.signal_level} >= rssi_lim)
               || (dlat >= r_move_thr) || (dlon >= r_move_thr);
        if (!forward) outcome = odhf_pkg::OUT_DUP;
        else if (!r_in.sink_accepts) outcome = odhf_pkg::OUT_FAIL;
        else outcome = odhf_pkg::OUT_FWD;
    end

    always_comb begin
        o_sts.clr_done  = r_clr_idx == LAST_ADDR;
        o_sts.hash_done = r_hash_cnt == odhf_pkg::HASH_LAST;
        o_sts.mod_done  = r_mod_cnt == odhf_pkg::MOD_LAST;
        o_sts.found     = slot_free || slot_match;
        o_sts.last      = last;
        o_sts.out_busy  = r_out_valid && i_out_stall;
    end

    // slot store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_cmd.commit && outcome == odhf_pkg::OUT_FWD) begin
            r_mem[wr_addr] <= {1'b1, r_in.device_address, r_in.signal_level,
                               r_in.latitude_offset, r_in.longitude_offset};
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_rssi_thr  <= odhf_pkg::RSSI_THR_RESET;
            r_move_thr  <= odhf_pkg::MOVE_THR_RESET;
        end else begin
            if (i_cmd.clr && r_clr_idx != LAST_ADDR) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.commit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    odhf_pkg::CFG_RSSI_THR: r_rssi_thr <= i_cfg_data[7:0];
                    odhf_pkg::CFG_MOVE_THR: r_move_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in       <= i_in_data;
            r_hash     <= odhf_pkg::FNV_BASIS;
            r_hsh_addr <= i_in_data.device_address;
            r_hash_cnt <= '0;
            r_mod_cnt  <= '0;
            r_rem      <= '0;
        end
        if (i_cmd.hash) begin
            r_hash     <= hash_n;
            r_hsh_addr <= {r_hsh_addr[39:0], 8'd0};
            r_hash_cnt <= r_hash_cnt + 1'b1;
        end
        if (i_cmd.mod_step) begin
            if (r_mod_cnt == 2'd0) begin
                r_mq <= rcp_prod[63:32];
            end else if (r_mod_cnt == 2'd1) begin
                r_mq <= r_hash - r_mq * size_w;
            end else begin
                r_rem <= (r_mq >= size_w) ? SLOT_W'(r_mq - size_w) : SLOT_W'(r_mq);
            end
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
        if (i_cmd.pinit) begin
            r_s     <= r_rem;
            r_cnt   <= '0;
            r_slot  <= r_rem;
            r_known <= 1'b0;
            r_full  <= 1'b1;
        end
        if (i_cmd.chk) begin
            if (slot_free) begin
                r_slot <= r_s;
                r_full <= 1'b0;
            end else if (slot_match) begin
                r_slot  <= r_s;
                r_known <= 1'b1;
                r_full  <= 1'b0;
            end else if (last) begin
                r_slot <= r_rem;
            end else begin
                r_s   <= ((SLOT_W + 1)'(r_s) == size - 1'b1) ? '0 : r_s + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_out.outcome    <= outcome;
            r_out.was_known  <= r_known;
            r_out.table_full <= r_full;
            r_out.slot_index <= 9'(r_slot);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/observation_dedup_hash_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// observation_dedup_hash_filter
// Drops repeated radio observations using FNV-1a hashed, linearly probed
// WiFi and BLE slot tables held in one store.
// ----------------------------------------------------------------------------
// One observation is processed at a time, from acceptance to result: the
// hash takes one byte per multiply over six bytes, the modulo by reciprocal
// multiplication takes three steps, then a probe setup, then for each of P
// probed slots (1 up to the table size) a read through the single-port store
// with registered read and a check, and then the commit. The commit
// waits while the previous result is still stalled. The next observation is
// taken the cycle after the commit, while the result waits.
// After reset a clearing pass over all WIFI_SLOTS + BLE_SLOTS slots (768 by
// default) runs before the first observation is accepted; configuration
// writes are taken at any time.
module observation_dedup_hash_filter #(
    parameter int WIFI_SLOTS = 256,
    parameter int BLE_SLOTS  = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  odhf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output odhf_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    odhf_pkg::t_cmd cmd;
    odhf_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    odhf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    odhf_dp #(
        .WIFI_SLOTS (WIFI_SLOTS),
        .BLE_SLOTS  (BLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sim/observation_dedup_hash_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// observation_dedup_hash_filter_tb
// Drives observations through the dedup filter with random gaps and stalls,
// predicts each outcome with a local hash-table model and checks every field.
// Thresholds are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module observation_dedup_hash_filter_tb;

    localparam int WIFI_N = 256;
    localparam int BLE_N  = 512;
    localparam int DEPTH  = WIFI_N + BLE_N;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    odhf_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    odhf_pkg::t_out_item o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    observation_dedup_hash_filter #(.WIFI_SLOTS(WIFI_N), .BLE_SLOTS(BLE_N)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // model state
    logic [7:0]       rssi_thr;
    logic [31:0]      move_thr;
    odhf_pkg::t_entry slots [DEPTH];

    odhf_pkg::t_in_item  obs_queue [$];
    odhf_pkg::t_out_item verdict_queue [$];
    int                  n_errors;
    logic [47:0]         addr_pool [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fnv_hash(logic [47:0] a);
        logic [31:0] h;
        h = odhf_pkg::FNV_BASIS;
        for (int k = 0; k < 6; k++) begin
            h = h ^ {24'd0, a[47 - 8*k -: 8]};
            h = h * odhf_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic [31:0] coord_delta(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic odhf_pkg::t_out_item filter_observation(odhf_pkg::t_in_item it);
        odhf_pkg::t_out_item r;
        int size, base, home, slot, g;
        logic known, full, fwd;
        size  = it.mode ? BLE_N : WIFI_N;
        base  = it.mode ? WIFI_N : 0;
        home  = fnv_hash(it.device_address) % size;
        slot  = home;
        known = 1'b0;
        full  = 1'b1;
        for (int i = 0; i < size; i++) begin
            g = base + (home + i) % size;
            if (!slots[g].valid) begin
                slot = (home + i) % size; full = 1'b0; break;
            end
            if (slots[g].address == it.device_address) begin
                slot = (home + i) % size; known = 1'b1; full = 1'b0; break;
            end
        end
        g = base + slot;
        if (!known)
            fwd = 1'b1;
        else if ($signed({1'b0, it.signal_level}) - $signed({1'b0, slots[g].signal})
                 >= $signed({1'b0, rssi_thr}))
            fwd = 1'b1;
        else
            fwd = coord_delta(it.latitude_offset, slots[g].latitude) >= move_thr ||
                  coord_delta(it.longitude_offset, slots[g].longitude) >= move_thr;
        if (!fwd)
            r.outcome = odhf_pkg::OUT_DUP;
        else if (!it.sink_accepts)
            r.outcome = odhf_pkg::OUT_FAIL;
        else begin
            r.outcome = odhf_pkg::OUT_FWD;
            slots[g] = '{1'b1, it.device_address, it.signal_level,
                         it.latitude_offset, it.longitude_offset};
        end
        r.was_known  = known;
        r.table_full = full;
        r.slot_index = slot[8:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            verdict_queue.push_back(filter_observation(i_in_data));
            in_gap = gap_len();
            if (in_gap == 0 && obs_queue.size() > 0) begin
                i_in_data <= obs_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            else if (obs_queue.size() > 0) begin
                i_in_data  <= obs_queue.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // monitor
    int out_gap;
    always @(posedge i_clk) begin
        odhf_pkg::t_out_item exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    $error("unexpected transaction: %p", o_out_data);
                    n_errors++;
                end else begin
                    exp_r = verdict_queue.pop_front();
                    if (o_out_data.outcome !== exp_r.outcome) begin
                        $error("outcome: expected %0d actual %0d", exp_r.outcome,
                               o_out_data.outcome);
                        n_errors++;
                    end
                    if (o_out_data.was_known !== exp_r.was_known) begin
                        $error("was_known: expected %0d actual %0d", exp_r.was_known,
                               o_out_data.was_known);
                        n_errors++;
                    end
                    if (o_out_data.table_full !== exp_r.table_full) begin
                        $error("table_full: expected %0d actual %0d", exp_r.table_full,
                               o_out_data.table_full);
                        n_errors++;
                    end
                    if (o_out_data.slot_index !== exp_r.slot_index) begin
                        $error("slot_index: expected %0d actual %0d", exp_r.slot_index,
                               o_out_data.slot_index);
                        n_errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                i_out_stall <= 1'b1;
                out_gap     <= out_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
                out_gap     <= gap_len();
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == odhf_pkg::CFG_RSSI_THR) rssi_thr = val[7:0];
        else if (idx == odhf_pkg::CFG_MOVE_THR) move_thr = val;
    endtask

    task automatic wait_drained();
        while (obs_queue.size() > 0 || i_in_valid || verdict_queue.size() > 0)
            @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    function automatic odhf_pkg::t_in_item make_obs(logic m, logic [47:0] a,
                                                    logic [7:0] s, logic [31:0] la,
                                                    logic [31:0] lo, logic acc);
        odhf_pkg::t_in_item it;
        it.mode = m; it.device_address = a; it.signal_level = s;
        it.latitude_offset = la; it.longitude_offset = lo; it.sink_accepts = acc;
        return it;
    endfunction

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom(), $urandom()});
    endfunction

    // revisits tracked addresses with nearby or shifted values
    task automatic queue_random(int n, int pool_max);
        odhf_pkg::t_in_item it;
        logic [47:0] a;
        for (int k = 0; k < n; k++) begin
            if (addr_pool.size() > 0 && $urandom_range(0, 99) < 65)
                a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            else begin
                a = rand_addr();
                if (addr_pool.size() < pool_max) addr_pool.push_back(a);
            end
            it = make_obs(1'($urandom_range(0, 1)), a, 8'($urandom()), $urandom(),
                          $urandom(), $urandom_range(0, 99) < 80);
            if ($urandom_range(0, 1)) begin
                it.latitude_offset  = 32'h8000_0000 + $urandom_range(0, 6000);
                it.longitude_offset = 32'h8000_0000 + $urandom_range(0, 6000);
                it.signal_level     = 8'(8'd100 + $urandom_range(0, 12));
            end
            obs_queue.push_back(it);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = odhf_pkg::CFG_RSSI_THR;
        i_cfg_data  = '0;
        n_errors    = 0;
        rssi_thr    = odhf_pkg::RSSI_THR_RESET;
        move_thr    = odhf_pkg::MOVE_THR_RESET;
        foreach (slots[i]) slots[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicate filtering, rssi rise and drop, moves, refusal
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd0, 32'd0, 32'd0, 1'b1));
        obs_queue.push_back(make_obs(1'b1, 48'hFFFF_FFFF_FFFF, 8'd255, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1'b1));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd0, 32'd0, 32'd0, 1'b1));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd6, 32'd0, 32'd0, 1'b0));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd5, 32'd0, 32'd0, 1'b1));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd11, 32'd0, 32'd0, 1'b1));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd0, 32'd2699, 32'd0, 1'b1));
        obs_queue.push_back(make_obs(1'b0, 48'h0, 8'd0, 32'd0, 32'd2700, 1'b1));
        obs_queue.push_back(make_obs(1'b1, 48'hFFFF_FFFF_FFFF, 8'd254, 32'hFFFF_F5A4,
                                     32'hFFFF_FFFF, 1'b1));
        obs_queue.push_back(make_obs(1'b1, 48'hFFFF_FFFF_FFFF, 8'd0, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1'b1));
        obs_queue.push_back(make_obs(1'b1, 48'hA5A5_5A5A_0F0F, 8'h5A, 32'h5A5A_A5A5,
                                     32'hA5A5_5A5A, 1'b0));
        obs_queue.push_back(make_obs(1'b1, 48'h5A5A_A5A5_F0F0, 8'hA5, 32'hA5A5_5A5A,
                                     32'h5A5A_A5A5, 1'b1));
        wait_drained();

        // fill the wifi table to force evictions
        write_reg(odhf_pkg::CFG_RSSI_THR, 32'd0);
        write_reg(odhf_pkg::CFG_MOVE_THR, 32'hFFFF_FFFF);
        for (int k = 0; k < 262; k++)
            obs_queue.push_back(make_obs(1'b0, {16'h1234, k[31:0]}, 8'($urandom()),
                                         $urandom(), $urandom(), 1'b1));
        wait_drained();

        write_reg(odhf_pkg::CFG_RSSI_THR, 32'd255);
        write_reg(odhf_pkg::CFG_MOVE_THR, 32'd0);
        addr_pool.delete();
        queue_random(40, 16);
        wait_drained();

        write_reg(odhf_pkg::CFG_RSSI_THR, 32'd6);
        write_reg(odhf_pkg::CFG_MOVE_THR, 32'd2700);
        write_reg(2'd3, 32'hFFFF_FFFF);
        addr_pool.delete();
        queue_random(150, 60);
        wait_drained();

        write_reg(odhf_pkg::CFG_RSSI_THR, $urandom_range(1, 20));
        write_reg(odhf_pkg::CFG_MOVE_THR, $urandom_range(100, 5000));
        queue_random(100, 80);
        wait_drained();

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
